[design/cfla_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfla_pkg: shared types and constants for the chunk free-list allocator
// Request and response payloads, configuration, controller commands and
// datapath status.
// ----------------------------------------------------------------------------
package cfla_pkg;

	typedef enum logic [1:0] {
		OP_ACQUIRE = 2'd0,
		OP_RELEASE = 2'd1,
		OP_LOCATE  = 2'd2,
		OP_FORMAT  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_BAD       = 2'd2,
		ST_NONE_HELD = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		OWN_BEFORE = 2'd0,
		OWN_INSIDE = 2'd1,
		OWN_AFTER  = 2'd2
	} owner_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PREP,
		S_EVAL,
		S_DIV,
		S_REL,
		S_FMT,
		S_FINISH
	} state_t;

	localparam logic [1:0] REG_BASE_ADDRESS = 2'd0;
	localparam logic [1:0] REG_NUM_BLOCKS   = 2'd1;
	localparam logic [1:0] REG_BLOCK_SIZE   = 2'd2;

	localparam int unsigned ADDR_W  = 32;
	localparam int unsigned IDX_W   = 8;
	localparam int unsigned SIZE_W  = 16;
	localparam int unsigned SPAN_W  = IDX_W + SIZE_W;
	localparam int unsigned DCNT_W  = $clog2(SPAN_W + 1);

	typedef struct packed {
		op_t               op;
		logic [ADDR_W-1:0] address;
	} req_t;

	typedef struct packed {
		status_t           status;
		logic [ADDR_W-1:0] block_address;
		owner_t            owner;
		logic [IDX_W-1:0]  free_count;
	} rsp_t;

	typedef struct packed {
		logic [ADDR_W-1:0] base_address;
		logic [IDX_W-1:0]  num_blocks;
		logic [SIZE_W-1:0] block_size;
	} cfg_t;

	typedef struct packed {
		logic    capture;
		logic    prep;
		logic    acq_commit;
		logic    rel_commit;
		logic    div_init;
		logic    div_step;
		logic    fmt_init;
		logic    fmt_step;
		logic    fmt_commit;
		logic    locate;
		logic    set_status;
		status_t status;
		logic    out_load;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic empty;
		logic out_range;
		logic full;
		logic div_last;
		logic rem_nz;
		logic sweep_done;
	} sts_t;

endpackage

[design/cfla_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfla_ctrl: allocator sequencer
// Steps one request through prepare, evaluate, divide or sweep, and hands
// the result to the response register.
// ----------------------------------------------------------------------------
module cfla_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	input  cfla_pkg::sts_t  sts,
	output cfla_pkg::cmd_t  cmd
);
	import cfla_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) state_d = S_PREP;
			end
			S_PREP: state_d = S_EVAL;
			S_EVAL: begin
				unique case (sts.op)
					OP_RELEASE: state_d = sts.out_range ? S_FINISH : S_DIV;
					OP_FORMAT:  state_d = S_FMT;
					default:    state_d = S_FINISH;
				endcase
			end
			S_DIV: begin
				if (sts.div_last) state_d = S_REL;
			end
			S_REL: state_d = S_FINISH;
			S_FMT: begin
				if (sts.sweep_done) state_d = S_FINISH;
			end
			S_FINISH: begin
				if (!out_valid_q || rsp_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		cmd.status = ST_OK;
		unique case (state_q)
			S_IDLE: cmd.capture = req_valid;
			S_PREP: cmd.prep = 1'b1;
			S_EVAL: begin
				unique case (sts.op)
					OP_ACQUIRE: begin
						if (sts.empty) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_EMPTY;
						end else begin
							cmd.acq_commit = 1'b1;
						end
					end
					OP_RELEASE: begin
						if (sts.out_range) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_BAD;
						end else begin
							cmd.div_init = 1'b1;
						end
					end
					OP_LOCATE: cmd.locate   = 1'b1;
					OP_FORMAT: cmd.fmt_init = 1'b1;
					default: ;
				endcase
			end
			S_DIV: cmd.div_step = 1'b1;
			S_REL: begin
				if (sts.rem_nz) begin
					cmd.set_status = 1'b1;
					cmd.status     = ST_BAD;
				end else if (sts.full) begin
					cmd.set_status = 1'b1;
					cmd.status     = ST_NONE_HELD;
				end else begin
					cmd.rel_commit = 1'b1;
				end
			end
			S_FMT: begin
				if (sts.sweep_done) begin
					cmd.fmt_commit = 1'b1;
				end else begin
					cmd.fmt_step = 1'b1;
				end
			end
			S_FINISH: cmd.out_load = !out_valid_q || rsp_ready;
			default: ;
		endcase
	end

endmodule

[design/cfla_dpath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfla_dpath: allocator datapath
// Link memory, head and free count, range arithmetic, restoring divider
// for release offsets, format sweep counter and the response register.
// ----------------------------------------------------------------------------
module cfla_dpath #(
	parameter int unsigned MAX_BLOCKS = 255
) (
	input  logic           clk,
	input  logic           arst_n,
	input  cfla_pkg::cfg_t cfg,
	input  cfla_pkg::req_t req,
	input  cfla_pkg::cmd_t cmd,
	output cfla_pkg::sts_t sts,
	output cfla_pkg::rsp_t rsp
);
	import cfla_pkg::*;

	localparam int unsigned AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam logic [IDX_W-1:0] MAX_IDX = IDX_W'(MAX_BLOCKS);

	logic [IDX_W-1:0]  link_mem [MAX_BLOCKS];

	op_t               op_q;
	logic [ADDR_W-1:0] addr_q;
	logic [IDX_W-1:0]  head_q;
	logic [IDX_W-1:0]  free_q;
	logic [ADDR_W:0]   offset_q;
	logic [SPAN_W-1:0] span_q;
	logic [SPAN_W-1:0] acq_prod_q;
	logic [IDX_W-1:0]  link_rd_q;
	logic [SIZE_W-1:0] rem_q;
	logic [SPAN_W-1:0] quo_q;
	logic [DCNT_W-1:0] div_cnt_q;
	logic [IDX_W-1:0]  fmt_cnt_q;
	status_t           res_status_q;
	logic [ADDR_W-1:0] res_baddr_q;
	owner_t            res_owner_q;
	rsp_t              rsp_q;

	logic [SIZE_W-1:0] eff_size;
	logic [SIZE_W:0]   trial;
	logic              trial_ge;
	logic [IDX_W-1:0]  rel_idx;
	logic              mem_we;
	logic [AW-1:0]     mem_wa;
	logic [IDX_W-1:0]  mem_wd;
	logic              below;

	assign eff_size = (cfg.block_size == '0) ? SIZE_W'(1) : cfg.block_size;
	assign below    = offset_q[ADDR_W];
	assign trial    = {rem_q, quo_q[SPAN_W-1]};
	assign trial_ge = trial >= {1'b0, eff_size};
	assign rel_idx  = quo_q[IDX_W-1:0];

	assign sts.op         = op_q;
	assign sts.empty      = (free_q == '0);
	assign sts.out_range  = below || (offset_q[ADDR_W-1:0] >= ADDR_W'(span_q));
	assign sts.full       = (free_q >= cfg.num_blocks);
	assign sts.div_last   = (div_cnt_q == DCNT_W'(1));
	assign sts.rem_nz     = (rem_q != '0);
	assign sts.sweep_done = (fmt_cnt_q >= cfg.num_blocks) || (fmt_cnt_q >= MAX_IDX);

	always_comb begin
		mem_we = 1'b0;
		mem_wa = fmt_cnt_q[AW-1:0];
		mem_wd = fmt_cnt_q + IDX_W'(1);
		if (cmd.rel_commit) begin
			mem_we = (rel_idx < MAX_IDX);
			mem_wa = rel_idx[AW-1:0];
			mem_wd = head_q;
		end else if (cmd.fmt_step) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) link_mem[mem_wa] <= mem_wd;
		if (cmd.prep) link_rd_q <= link_mem[head_q[AW-1:0]];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			free_q    <= '0;
			div_cnt_q <= '0;
			fmt_cnt_q <= '0;
		end else begin
			if (cmd.acq_commit) begin
				head_q <= (head_q >= MAX_IDX) ? '0 : link_rd_q;
				free_q <= free_q - IDX_W'(1);
			end else if (cmd.rel_commit) begin
				head_q <= rel_idx;
				free_q <= free_q + IDX_W'(1);
			end else if (cmd.fmt_commit) begin
				head_q <= '0;
				free_q <= cfg.num_blocks;
			end
			if (cmd.div_init) begin
				div_cnt_q <= DCNT_W'(SPAN_W);
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q - DCNT_W'(1);
			end
			if (cmd.fmt_init) begin
				fmt_cnt_q <= '0;
			end else if (cmd.fmt_step) begin
				fmt_cnt_q <= fmt_cnt_q + IDX_W'(1);
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= req.op;
			addr_q <= req.address;
		end
		if (cmd.prep) begin
			offset_q     <= {1'b0, addr_q} - {1'b0, cfg.base_address};
			span_q       <= SPAN_W'(cfg.num_blocks) * SPAN_W'(eff_size);
			acq_prod_q   <= SPAN_W'(head_q) * SPAN_W'(eff_size);
			res_status_q <= ST_OK;
			res_baddr_q  <= '0;
			res_owner_q  <= OWN_BEFORE;
		end
		if (cmd.acq_commit) res_baddr_q <= cfg.base_address + ADDR_W'(acq_prod_q);
		if (cmd.set_status) res_status_q <= cmd.status;
		if (cmd.locate) begin
			if (below) begin
				res_owner_q <= OWN_BEFORE;
			end else if (sts.out_range) begin
				res_owner_q <= OWN_AFTER;
			end else begin
				res_owner_q <= OWN_INSIDE;
			end
		end
		if (cmd.div_init) begin
			rem_q <= '0;
			quo_q <= offset_q[SPAN_W-1:0];
		end else if (cmd.div_step) begin
			rem_q <= trial_ge ? SIZE_W'(trial - {1'b0, eff_size}) : trial[SIZE_W-1:0];
			quo_q <= {quo_q[SPAN_W-2:0], trial_ge};
		end
		if (cmd.out_load) begin
			rsp_q.status        <= res_status_q;
			rsp_q.block_address <= res_baddr_q;
			rsp_q.owner         <= res_owner_q;
			rsp_q.free_count    <= free_q;
		end
	end

	assign rsp = rsp_q;

endmodule

[design/chunk_free_list_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunk_free_list_allocator: free-list allocator for one chunk of blocks
// Acquire, release, locate and format requests against a chunk of up to
// MAX_BLOCKS equal blocks, with an APB register port for the chunk layout.
//
//   channel  handshake               payload
//   req      req_valid / req_ready   req  (op, address)
//   rsp      rsp_valid / rsp_ready   rsp  (status, block_address, owner, free_count)
//   apb      psel, penable, pwrite   paddr, pwdata, prdata, pready
//
// One request at a time. Acquire, locate and a release outside the chunk pass
// through prepare and evaluate to the response register; a release inside
// the chunk also runs the 24-step restoring divider; format sweeps the links,
// one link write per cycle.
// A new request is taken while the previous response still waits.
// Reset clears head and free count; link memory is written by format.
// ----------------------------------------------------------------------------
module chunk_free_list_allocator #(
	parameter int unsigned MAX_BLOCKS = 255
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  cfla_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output cfla_pkg::rsp_t rsp,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [3:0]     paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready
);
	import cfla_pkg::*;

	cfg_t       cfg_q;
	cmd_t       cmd;
	sts_t       sts;
	logic [1:0] reg_idx;
	logic       wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_address <= '0;
			cfg_q.num_blocks   <= 8'd255;
			cfg_q.block_size   <= 16'd1;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_BASE_ADDRESS: cfg_q.base_address <= pwdata;
				REG_NUM_BLOCKS:   cfg_q.num_blocks   <= pwdata[IDX_W-1:0];
				REG_BLOCK_SIZE:   cfg_q.block_size   <= pwdata[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_BASE_ADDRESS: prdata = cfg_q.base_address;
			REG_NUM_BLOCKS:   prdata = 32'(cfg_q.num_blocks);
			REG_BLOCK_SIZE:   prdata = 32'(cfg_q.block_size);
			default:          prdata = '0;
		endcase
	end

	cfla_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	cfla_dpath #(
		.MAX_BLOCKS (MAX_BLOCKS)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp)
	);

endmodule
